[rtl/sorted_key_list_engine_top_defines.svh]
// Assertion macros shared by the sorted key list engine RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef SORTED_KEY_LIST_ENGINE_TOP_DEFINES_SVH
`define SORTED_KEY_LIST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SKL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/skl_pkg.sv]
// Package for the sorted key list engine: sizes, operation and status codes,
// transaction structs and the cell control struct. No dependencies.
package skl_pkg;

  localparam int SKL_DEPTH      = 16;
  localparam int SKL_KEY_BITS   = 32;
  localparam int SKL_VALUE_BITS = 32;

  // Operation codes (kind field)
  localparam logic [2:0] KIND_APPEND = 3'd0;
  localparam logic [2:0] KIND_INSERT = 3'd1;
  localparam logic [2:0] KIND_POP    = 3'd2;
  localparam logic [2:0] KIND_FIND   = 3'd3;
  localparam logic [2:0] KIND_REMOVE = 3'd4;
  localparam logic [2:0] KIND_READ   = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] search_key;
    logic [31:0] entry_value;
    logic [3:0]  position;
  } skl_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] key_out;
    logic [31:0] value_out;
    logic [3:0]  found_position;
    logic [4:0]  entry_count;
  } skl_out_t;

  typedef enum logic [1:0] {
    CM_KEEP = 2'd0,
    CM_LOAD = 2'd1,
    CM_PREV = 2'd2,
    CM_NEXT = 2'd3
  } skl_cell_mode_t;

  typedef struct packed {
    skl_cell_mode_t mode;
    logic           cmp_en;
  } skl_cell_ctl_t;

endpackage

[rtl/skl_cell.sv]
// One list cell: holds a key/value pair, compares its key against the search
// key and shifts with its neighbors. Depends on skl_pkg.
module skl_cell
  import skl_pkg::*;
#(
  parameter int KEY_BITS   = SKL_KEY_BITS,
  parameter int VALUE_BITS = SKL_VALUE_BITS
) (
  input  logic                  clk,
  input  skl_cell_ctl_t         ctl,
  input  logic [KEY_BITS-1:0]   new_key,
  input  logic [VALUE_BITS-1:0] new_value,
  input  logic [KEY_BITS-1:0]   cmp_key,
  input  logic [KEY_BITS-1:0]   prev_key,
  input  logic [VALUE_BITS-1:0] prev_value,
  input  logic [KEY_BITS-1:0]   next_key,
  input  logic [VALUE_BITS-1:0] next_value,
  output logic [KEY_BITS-1:0]   key,
  output logic [VALUE_BITS-1:0] value,
  output logic                  gt,
  output logic                  eq
);

  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic                  gt_r, eq_r;

  always_comb begin
    case (ctl.mode)
      CM_LOAD: begin
        key_nxt   = new_key;
        value_nxt = new_value;
      end
      CM_PREV: begin
        key_nxt   = prev_key;
        value_nxt = prev_value;
      end
      CM_NEXT: begin
        key_nxt   = next_key;
        value_nxt = next_value;
      end
      default: begin
        key_nxt   = key_r;
        value_nxt = value_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
    if (ctl.cmp_en) begin
      gt_r <= key_r > cmp_key;
      eq_r <= key_r == cmp_key;
    end
  end

  assign key   = key_r;
  assign value = value_r;
  assign gt    = gt_r;
  assign eq    = eq_r;

endmodule

[rtl/skl_first.sv]
// First-set finder over the cell flag row: log-depth prefix OR, then
// one-hot isolate and binary encode. Depends on skl_pkg.
module skl_first
  import skl_pkg::*;
#(
  parameter int N     = SKL_DEPTH,
  parameter int IDX_W = $clog2(SKL_DEPTH)
) (
  input  logic [N-1:0]     req,
  output logic             found,
  output logic [IDX_W-1:0] idx
);

  localparam int LV = $clog2(N);

  logic [N-1:0] pre [LV+1];
  logic [N-1:0] first_oh;

  always_comb begin
    pre[0] = req;
    for (int l = 0; l < LV; l++) begin
      for (int i = 0; i < N; i++) begin
        if (i >= (1 << l)) begin
          pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
        end else begin
          pre[l+1][i] = pre[l][i];
        end
      end
    end
  end

  always_comb begin
    first_oh[0] = req[0];
    for (int i = 1; i < N; i++) begin
      first_oh[i] = req[i] & ~pre[LV][i-1];
    end
  end

  always_comb begin
    idx = '0;
    for (int i = 0; i < N; i++) begin
      idx = idx | (first_oh[i] ? IDX_W'(i) : '0);
    end
  end

  assign found = |req;

endmodule

[rtl/sorted_key_list_engine_top.sv]
// Sorted key list engine: an ordered list of up to DEPTH key/value entries
// kept in a row of cells. A command is taken when start is high and busy is
// low; every command produces exactly one result transaction, shown on
// out_data for a single cycle with out_valid high. The receiver cannot stall
// the block, so results must be captured in the cycle out_valid is high.
// Each command goes from acceptance to the result strobe through accept,
// parallel compare in every cell, first-match search and apply/shift, and
// busy falls in the result cycle, so no new command is taken before the
// previous result. The compare-then-search-then-shift sequence over the
// cell row is the same for any DEPTH.
// Depends on skl_pkg, skl_cell, skl_first and the assertion macro header.
`include "sorted_key_list_engine_top_defines.svh"

module sorted_key_list_engine_top
  import skl_pkg::*;
#(
  parameter int DEPTH      = SKL_DEPTH,
  parameter int KEY_BITS   = SKL_KEY_BITS,
  parameter int VALUE_BITS = SKL_VALUE_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  skl_in_t  in_data,
  output logic     out_valid,
  output skl_out_t out_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Sequencer: one-hot states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_FIND  = 4'b0100,
    S_APPLY = 4'b1000
  } skl_state_t;

  skl_state_t state_r, state_nxt;

  skl_in_t    cmd_r;
  logic       accept;

  logic [CNT_W-1:0] count_r, count_nxt, count_after;

  // Decision registered at the end of the search cycle
  logic [IDX_W-1:0] at_r, at_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             ins_r, ins_nxt;
  logic             del_r, del_nxt;
  logic             rep_r, rep_nxt;

  logic     out_valid_r;
  skl_out_t out_r, out_nxt;

  // Cell row
  logic [KEY_BITS-1:0]   keys [DEPTH];
  logic [VALUE_BITS-1:0] vals [DEPTH];
  logic [DEPTH-1:0]      gt_v, eq_v;
  skl_cell_ctl_t         ctl  [DEPTH];

  logic [KEY_BITS-1:0]   cmd_key, new_key;
  logic [VALUE_BITS-1:0] new_val;

  // Search inputs
  logic [DEPTH-1:0] valid_v, tail_oh, first_req;
  logic             first_found, tail_gt, full, empty, pos_ok;
  logic [IDX_W-1:0] first_idx, count_idx;

  // Read-out of the addressed entry
  logic [KEY_BITS-1:0]   ko;
  logic [VALUE_BITS-1:0] vo;

  assign accept  = start & ~busy;
  assign busy    = (state_r != S_IDLE);

  // Keys and values wrap to the configured widths
  assign cmd_key = KEY_BITS'(cmd_r.search_key);
  assign new_key = (cmd_r.kind == KIND_APPEND) ? '0 : cmd_key;
  assign new_val = VALUE_BITS'(cmd_r.entry_value);

  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = accept ? S_CMP : S_IDLE;
      S_CMP:   state_nxt = S_FIND;
      S_FIND:  state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Cell row. Cell 0 has nothing before it; the last cell refills from
  // itself on a close, which is harmless since it drops out of the count.
  // ---------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_BITS-1:0]   p_key, n_key;
    logic [VALUE_BITS-1:0] p_val, n_val;

    if (g == 0) begin : g_head
      assign p_key = '0;
      assign p_val = '0;
    end else begin : g_mid
      assign p_key = keys[g-1];
      assign p_val = vals[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign n_key = keys[g];
      assign n_val = vals[g];
    end else begin : g_body
      assign n_key = keys[g+1];
      assign n_val = vals[g+1];
    end

    skl_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl[g]),
      .new_key    (new_key),
      .new_value  (new_val),
      .cmp_key    (cmd_key),
      .prev_key   (p_key),
      .prev_value (p_val),
      .next_key   (n_key),
      .next_value (n_val),
      .key        (keys[g]),
      .value      (vals[g]),
      .gt         (gt_v[g]),
      .eq         (eq_v[g])
    );
  end

  // ---------------------------------------------------------------------
  // Search cycle: cell flags are registered, mask them by occupancy and
  // pick the first hit. With the tail key above the new key, the first
  // cell whose key is greater is exactly the insert point (head included).
  // ---------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_v[i] = 32'(i) < 32'(count_r);
      tail_oh[i] = (32'(i) + 32'd1) == 32'(count_r);
    end
  end

  assign first_req = ((cmd_r.kind == KIND_FIND) ? eq_v : gt_v) & valid_v;
  assign tail_gt   = |(gt_v & tail_oh);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign pos_ok    = 32'(cmd_r.position) < 32'(count_r);
  assign count_idx = IDX_W'(count_r);

  skl_first #(
    .N     (DEPTH),
    .IDX_W (IDX_W)
  ) u_first (
    .req   (first_req),
    .found (first_found),
    .idx   (first_idx)
  );

  always_comb begin
    status_nxt = ST_OK;
    at_nxt     = '0;
    ins_nxt    = 1'b0;
    del_nxt    = 1'b0;
    rep_nxt    = 1'b0;
    case (cmd_r.kind)
      KIND_APPEND: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          at_nxt  = count_idx;
          ins_nxt = 1'b1;
        end
      end
      KIND_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          at_nxt  = (empty || !tail_gt) ? count_idx : first_idx;
          ins_nxt = 1'b1;
        end
      end
      KIND_POP: begin
        if (empty) begin
          status_nxt = ST_MISS;
        end else begin
          del_nxt = 1'b1;
          rep_nxt = 1'b1;
        end
      end
      KIND_FIND: begin
        if (first_found) begin
          at_nxt  = first_idx;
          rep_nxt = 1'b1;
        end else begin
          status_nxt = ST_MISS;
        end
      end
      KIND_REMOVE, KIND_READ: begin
        if (pos_ok) begin
          at_nxt  = IDX_W'(cmd_r.position);
          rep_nxt = 1'b1;
          del_nxt = (cmd_r.kind == KIND_REMOVE);
        end else begin
          status_nxt = ST_MISS;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Apply cycle: open a slot (cells above the point take their left
  // neighbor) or close one (cells from the point on take their right
  // neighbor). The addressed entry is read out before the shift lands.
  // ---------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].cmp_en = (state_r == S_CMP);
      ctl[i].mode   = CM_KEEP;
      if (state_r == S_APPLY) begin
        if (ins_r) begin
          if (32'(i) == 32'(at_r)) begin
            ctl[i].mode = CM_LOAD;
          end else if (32'(i) > 32'(at_r)) begin
            ctl[i].mode = CM_PREV;
          end
        end else if (del_r) begin
          if (32'(i) >= 32'(at_r)) begin
            ctl[i].mode = CM_NEXT;
          end
        end
      end
    end
  end

  always_comb begin
    ko = '0;
    vo = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (32'(i) == 32'(at_r)) begin
        ko = ko | keys[i];
        vo = vo | vals[i];
      end
    end
  end

  always_comb begin
    count_after = count_r;
    if (ins_r) begin
      count_after = count_r + CNT_W'(1);
    end else if (del_r) begin
      count_after = count_r - CNT_W'(1);
    end
  end

  assign count_nxt = (state_r == S_APPLY) ? count_after : count_r;

  always_comb begin
    out_nxt.status         = status_r;
    out_nxt.key_out        = rep_r ? 32'(ko) : '0;
    out_nxt.value_out      = rep_r ? 32'(vo) : '0;
    out_nxt.found_position = 4'(at_r);
    out_nxt.entry_count    = 5'(count_after);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (state_r == S_APPLY);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data;
    end
    if (state_r == S_FIND) begin
      at_r     <= at_nxt;
      status_r <= status_nxt;
      ins_r    <= ins_nxt;
      del_r    <= del_nxt;
      rep_r    <= rep_nxt;
    end
    if (state_r == S_APPLY) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `SKL_ASSERT_NEXT(a_accept_starts, accept, state_r == S_CMP, "accepted command did not start compare")
  `SKL_ASSERT_NOW(a_result_idle, out_valid_r, state_r == S_IDLE, "result strobe while still busy")
  `SKL_ASSERT_NOW(a_count_bound, 1'b1, 32'(count_r) <= DEPTH, "entry count beyond depth")
  `SKL_ASSERT_NOW(a_fail_no_change, out_valid_r && (out_r.status != ST_OK), count_r == $past(count_r), "failed command changed entry count")
  `SKL_ASSERT_NOW(a_full_count, out_valid_r && (out_r.status == ST_FULL), count_r == CNT_W'(DEPTH), "full status with room left")

endmodule

[bench/sorted_key_list_engine_top_test.sv]
`timescale 1ns / 100ps
// Self-checking test for sorted_key_list_engine_top: directed and random list commands
// checked against a built-in model of the sorted key list. Depends on skl_pkg and the RTL.

module sorted_key_list_engine_top_test;
  import skl_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 1950;
  // Give the tail a margin after the last expected result is checked.
  localparam int DRAIN_CYCLES = 8;
  // The longest legal quiet stretch is a sender gap plus a command's own processing.
  localparam int STALL_LIMIT  = 500;

  // Kinds with no defined operation: the block must leave the list alone.
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  logic     clk   = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  skl_in_t  in_data = '0;
  logic     out_valid;
  skl_out_t out_data;

  sorted_key_list_engine_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow copy of the list. Only slots below list_fill are ever read, so
  // stale contents above the fill level never matter.
  // ---------------------------------------------------------------------
  logic [SKL_KEY_BITS-1:0]   list_keys   [SKL_DEPTH];
  logic [SKL_VALUE_BITS-1:0] list_values [SKL_DEPTH];
  int                        list_fill = 0;

  // Results owed by the block, oldest first.
  skl_out_t pending_results[$];

  int  fail_count      = 0;
  int  results_checked = 0;
  int  kind_seen[8]    = '{default: 0};
  int  full_rejects    = 0;
  int  misses          = 0;
  int  peak_fill       = 0;

  // Sender burst/gap state; gaps_on is cleared for back-to-back stretches.
  int  burst_left = 0;
  bit  gaps_on    = 1'b1;

  function automatic skl_in_t mk_cmd(logic [2:0] kind, logic [31:0] key,
                                     logic [31:0] value, logic [3:0] pos);
    skl_in_t c;
    c.kind        = kind;
    c.search_key  = key;
    c.entry_value = value;
    c.position    = pos;
    return c;
  endfunction

  // Keys cluster on a few small values so duplicates and find hits are
  // common; the rest span the full range and its top end.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 4))
      0:       return $urandom();
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  // Applies one command to the shadow list and returns the result the
  // block owes for it. Fields with no meaning stay zero.
  function automatic skl_out_t apply_list_op(skl_in_t cmd);
    skl_out_t                r;
    int                      slot;
    int                      i;
    bit                      hit;
    logic [SKL_KEY_BITS-1:0] new_key;
    r    = '0;
    slot = 0;
    case (cmd.kind)
      KIND_APPEND, KIND_INSERT: begin
        if (list_fill >= SKL_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          new_key = (cmd.kind == KIND_APPEND) ? '0 : cmd.search_key;
          if (cmd.kind == KIND_APPEND || list_fill == 0 ||
              list_keys[list_fill-1] <= new_key) begin
            slot = list_fill;                  // goes on the tail
          end else if (list_keys[0] > new_key) begin
            slot = 0;                          // goes in front of the head
          end else begin
            // before the first later entry with a greater key
            slot = list_fill - 1;
            hit  = 1'b0;
            for (i = 1; i < list_fill; i++) begin
              if (!hit && list_keys[i] > new_key) begin
                slot = i;
                hit  = 1'b1;
              end
            end
          end
          for (i = list_fill; i > slot; i--) begin
            list_keys[i]   = list_keys[i-1];
            list_values[i] = list_values[i-1];
          end
          list_keys[slot]   = new_key;
          list_values[slot] = cmd.entry_value;
          list_fill++;
          r.found_position = 4'(slot);
        end
      end
      KIND_POP: begin
        if (list_fill == 0) begin
          r.status = ST_MISS;
        end else begin
          r.key_out   = list_keys[0];
          r.value_out = list_values[0];
          for (i = 0; i + 1 < list_fill; i++) begin
            list_keys[i]   = list_keys[i+1];
            list_values[i] = list_values[i+1];
          end
          list_fill--;
        end
      end
      KIND_FIND: begin
        r.status = ST_MISS;
        for (i = 0; i < list_fill; i++) begin
          if (r.status == ST_MISS && list_keys[i] == cmd.search_key) begin
            r.status         = ST_OK;
            r.found_position = 4'(i);
            r.key_out        = list_keys[i];
            r.value_out      = list_values[i];
          end
        end
      end
      KIND_REMOVE, KIND_READ: begin
        if (int'(cmd.position) >= list_fill) begin
          r.status = ST_MISS;
        end else begin
          r.found_position = cmd.position;
          r.key_out        = list_keys[cmd.position];
          r.value_out      = list_values[cmd.position];
          if (cmd.kind == KIND_REMOVE) begin
            for (i = cmd.position; i + 1 < list_fill; i++) begin
              list_keys[i]   = list_keys[i+1];
              list_values[i] = list_values[i+1];
            end
            list_fill--;
          end
        end
      end
      default: ;  // unused kinds: no change, status ok
    endcase
    r.entry_count = 5'(list_fill);
    return r;
  endfunction

  // Sends one command: holds start until the block takes it, records the
  // expected result, then maybe opens a gap before the next burst.
  task automatic issue_cmd(input skl_in_t cmd);
    skl_out_t want;
    int       gap;
    start   <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (busy);
    want = apply_list_op(cmd);
    pending_results.push_back(want);
    kind_seen[cmd.kind]++;
    if (want.status == ST_FULL) full_rejects++;
    if (want.status == ST_MISS) misses++;
    if (list_fill > peak_fill) peak_fill = list_fill;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 6);
      gap        = gaps_on ? $urandom_range(1, 7) : 0;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Result checker: every strobe must match the oldest outstanding
  // expectation. The strobe cannot be held off, so sample it every edge.
  // ---------------------------------------------------------------------
  skl_out_t got_want;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: %h", out_data);
        fail_count++;
      end else begin
        got_want = pending_results.pop_front();
        results_checked++;
        if (out_data.status !== got_want.status) begin
          $error("status: expected %0d, got %0d", got_want.status, out_data.status);
          fail_count++;
        end
        if (out_data.key_out !== got_want.key_out) begin
          $error("key_out: expected %h, got %h", got_want.key_out, out_data.key_out);
          fail_count++;
        end
        if (out_data.value_out !== got_want.value_out) begin
          $error("value_out: expected %h, got %h", got_want.value_out, out_data.value_out);
          fail_count++;
        end
        if (out_data.found_position !== got_want.found_position) begin
          $error("found_position: expected %0d, got %0d",
                 got_want.found_position, out_data.found_position);
          fail_count++;
        end
        if (out_data.entry_count !== got_want.entry_count) begin
          $error("entry_count: expected %0d, got %0d",
                 got_want.entry_count, out_data.entry_count);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a stretch with no command taken and no result seen means
  // the block has hung.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("sorted_key_list_engine_top verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Pop, find, read and remove on an empty list, plus the unused kinds.
  task automatic test_empty_list();
    issue_cmd(mk_cmd(KIND_POP,      32'h0,        32'h0,        4'd0));
    issue_cmd(mk_cmd(KIND_FIND,     32'h0,        32'h0,        4'd0));
    issue_cmd(mk_cmd(KIND_READ,     32'h0,        32'h0,        4'd15));
    issue_cmd(mk_cmd(KIND_REMOVE,   32'h0,        32'h0,        4'd0));
    issue_cmd(mk_cmd(KIND_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15));
    issue_cmd(mk_cmd(KIND_SPARE_HI, 32'h1234_5678, 32'h9ABC_DEF0, 4'd7));
  endtask

  // The three insert cases: tail (incl. equal tail key), head, and middle
  // with duplicates; then an append whose key field is ignored.
  task automatic test_keyed_insert();
    issue_cmd(mk_cmd(KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 4'd0));
    issue_cmd(mk_cmd(KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 4'd0));
    issue_cmd(mk_cmd(KIND_INSERT, 32'h8000_0000, 32'h0000_0001, 4'd0));
    issue_cmd(mk_cmd(KIND_INSERT, 32'h8000_0000, 32'h0000_0002, 4'd0));
    issue_cmd(mk_cmd(KIND_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 4'd0));
    issue_cmd(mk_cmd(KIND_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15));
    // first of the duplicate keys, then the zero key at the head
    issue_cmd(mk_cmd(KIND_FIND,   32'h8000_0000, 32'h0,        4'd0));
    issue_cmd(mk_cmd(KIND_FIND,   32'h0000_0000, 32'h0,        4'd0));
  endtask

  // Positional reads in range, at the tail and past the end, then a remove and a pop.
  task automatic test_position_ops();
    issue_cmd(mk_cmd(KIND_READ,   32'h0, 32'h0, 4'd0));
    issue_cmd(mk_cmd(KIND_READ,   32'h0, 32'h0, 4'd5));
    issue_cmd(mk_cmd(KIND_READ,   32'h0, 32'h0, 4'd6));
    issue_cmd(mk_cmd(KIND_REMOVE, 32'h0, 32'h0, 4'd2));
    issue_cmd(mk_cmd(KIND_POP,    32'h0, 32'h0, 4'd0));
  endtask

  // Fill the list, hit it with append and insert while full, and work the
  // last position.
  task automatic test_full_list();
    while (list_fill < SKL_DEPTH)
      issue_cmd(mk_cmd(KIND_INSERT, pick_key(), $urandom(), 4'd0));
    issue_cmd(mk_cmd(KIND_APPEND, 32'h0,        32'h1111_1111, 4'd0));
    issue_cmd(mk_cmd(KIND_INSERT, 32'h0000_0005, 32'h2222_2222, 4'd0));
    issue_cmd(mk_cmd(KIND_READ,   32'h0, 32'h0, 4'd15));
    issue_cmd(mk_cmd(KIND_REMOVE, 32'h0, 32'h0, 4'd15));
    issue_cmd(mk_cmd(KIND_READ,   32'h0, 32'h0, 4'd15));
  endtask

  // Random traffic in phases that alternately grow and drain the list, so
  // it keeps passing through both full and empty. Some phases run with no
  // sender gaps at all.
  task automatic test_random_traffic(input int n);
    int      counted;
    int      phase_left;
    bit      grow;
    int      roll;
    int      ins_cut, app_cut, pop_cut, find_cut, rem_cut, read_cut;
    skl_in_t cmd;
    counted    = 0;
    phase_left = 0;
    grow       = 1'b0;
    while (counted < n) begin
      if (phase_left == 0) begin
        grow       = !grow;
        phase_left = $urandom_range(30, 120);
        gaps_on    = ($urandom_range(0, 3) != 0);
      end
      phase_left--;
      if (grow) begin
        ins_cut = 45; app_cut = 55; pop_cut = 65; find_cut = 80; rem_cut = 87; read_cut = 97;
      end else begin
        ins_cut = 15; app_cut = 20; pop_cut = 50; find_cut = 65; rem_cut = 80; read_cut = 97;
      end
      roll = $urandom_range(0, 99);
      cmd  = mk_cmd(KIND_READ, pick_key(), $urandom(), 4'd0);
      if (roll < ins_cut)       cmd.kind = KIND_INSERT;
      else if (roll < app_cut)  cmd.kind = KIND_APPEND;
      else if (roll < pop_cut)  cmd.kind = KIND_POP;
      else if (roll < find_cut) cmd.kind = KIND_FIND;
      else if (roll < rem_cut)  cmd.kind = KIND_REMOVE;
      else if (roll < read_cut) cmd.kind = KIND_READ;
      else cmd.kind = $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
      // mostly valid positions, some past the fill level
      if (list_fill > 0 && $urandom_range(0, 9) < 7)
        cmd.position = 4'($urandom_range(0, list_fill - 1));
      else
        cmd.position = 4'($urandom_range(0, 15));
      // most finds look for a key that is present
      if (cmd.kind == KIND_FIND && list_fill > 0 && $urandom_range(0, 2) != 0)
        cmd.search_key = list_keys[$urandom_range(0, list_fill - 1)];
      issue_cmd(cmd);
      if (cmd.kind != KIND_SPARE_LO && cmd.kind != KIND_SPARE_HI) counted++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_keyed_insert();
    test_position_ops();
    test_full_list();
    test_random_traffic(RANDOM_ITEMS);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered append %0d, insert %0d, pop %0d, find %0d, remove %0d, read %0d, unused %0d",
             kind_seen[KIND_APPEND], kind_seen[KIND_INSERT], kind_seen[KIND_POP],
             kind_seen[KIND_FIND], kind_seen[KIND_REMOVE], kind_seen[KIND_READ],
             kind_seen[KIND_SPARE_LO] + kind_seen[KIND_SPARE_HI]);
    $display("Checked %0d results: %0d full rejects, %0d misses, peak fill %0d",
             results_checked, full_rejects, misses, peak_fill);
    if (fail_count == 0)
      $display("sorted_key_list_engine_top verification clean");
    else
      $display("sorted_key_list_engine_top verification failed");
    $finish;
  end

endmodule

[sorted_key_list_engine_top.f]
+incdir+rtl
rtl/skl_pkg.sv
rtl/skl_cell.sv
rtl/skl_first.sv
rtl/sorted_key_list_engine_top.sv
bench/sorted_key_list_engine_top_test.sv
